@@ sv/pss_pkg.sv @@
// Package for the priority sleep scheduler: widths, action codes, FSM states
// and the controller/datapath command and status structs. No dependencies.
package pss_pkg;
    localparam int MaxTasks  = 16;
    localparam int IdxW      = $clog2(MaxTasks);
    localparam int CntW      = IdxW + 1;
    localparam int PrioW     = 6;
    localparam int IdW       = 4;
    localparam int WakeW     = 32;
    localparam int SliceW    = 8;
    localparam logic [SliceW-1:0] SliceReset = 8'd4;
    localparam logic [SliceW-1:0] SliceMax   = 8'd255;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_UNBLOCK = 3'd1,
        ACT_CREATE  = 3'd2,
        ACT_YIELD   = 3'd3,
        ACT_SLEEP   = 3'd4,
        ACT_BLOCK   = 3'd5,
        ACT_EXIT    = 3'd6,
        ACT_SETPRIO = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,      // wait for input
        S_DECODE,    // pick what to do
        S_WAKE_CHK,  // check sleep head
        S_WAKE_POP,  // pop sleep head into insert buffer
        S_RINS,      // shift-insert into ready queue, one entry per cycle
        S_SINS,      // shift-insert into sleep queue, one entry per cycle
        S_SLICE,     // bump slice counter, maybe yield
        S_YIELD,     // evaluate yield
        S_YPOP,      // pop head into current, old current into insert buffer
        S_DISPATCH,  // pop head or go idle
        S_RESULT     // load result register
    } state_t;

    typedef struct packed {
        logic load_item;     // latch input fields
        logic clr_result;    // clear result flags
        logic ins_start;     // ready insert: start with buffer
        logic ins_step;      // ready insert: one shift step
        logic sins_start;
        logic sins_step;
        logic wake_pop;      // sleep head -> insert buffer
        logic yield_pop;     // swap current with ready head
        logic dispatch;      // pop head or go idle
        logic slice_inc;
        logic slice_clr;
        logic set_prio;
        logic buf_from_item; // insert buffer from item fields
        logic set_preempt;
        logic set_full;
        logic set_invalid;
        logic out_load;
    } pss_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       idle;
        logic       ready_full;
        logic       ready_empty;
        logic       sleep_full;
        logic       wake_due;       // sleep head due
        logic       ins_done;       // ready insert finds its place
        logic       sins_done;
        logic       head_ge_cur;    // ready head prio >= current prio
        logic       new_gt_cur;     // item prio > running (idle = 0)
        logic       new_gt_req;     // head prio > item prio
        logic       slice_expired;  // slice_count+1 saturated >= slice length
        logic       out_busy;
    } pss_stat_t;
endpackage

@@ sv/priority_sleep_scheduler.sv @@
// Top level of the priority sleep scheduler: controller plus datapath.
// Depends on pss_pkg, pss_ctrl and pss_datapath.
//
// Usage: one action enters on the s_ channel (valid/ready); exactly one
// result leaves on the m_ channel (valid/ready) for each action. The
// slice length register is written on cfg_valid/cfg_ready; the user must
// write it only while the block is quiet (not enforced by the block).
// cfg_ready is always high. A sorted insert walks the ready or sleep queue
// one entry per cycle until it finds its place. A tick pops each due sleeper
// and inserts it into the ready queue (or drops it with status full when that
// queue is full); a switching yield requeues the old task with an insert.
// The worst case is a tick that wakes 16 sleepers and then yields.
// One item is in work at a time; the next is accepted only once the result
// has been taken and the controller is back in S_IDLE.
// Reset (aresetn low, synchronous) empties both queues, makes the idle task
// run and sets the slice length to 4. No clearing pass is needed.
// When the receiver stalls, the result register holds and s_ready stays low.
module priority_sleep_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_task_id,
    input  logic [5:0]  s_priority_req,
    input  logic [31:0] s_tick_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_running_task,
    output logic [5:0]  m_running_priority,
    output logic        m_is_idle,
    output logic        m_switched,
    output logic        m_preempted,
    output logic [1:0]  m_status,
    output logic [4:0]  m_ready_count,
    output logic [4:0]  m_sleep_count
);
    import pss_pkg::*;

    pss_cmd_t  cmd;
    pss_stat_t stat;

    assign cfg_ready = 1'b1;

    pss_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .stat, .cmd
    );

    pss_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .s_action, .s_task_id, .s_priority_req, .s_tick_value,
        .cfg_data, .cfg_we(cfg_valid && cfg_ready),
        .m_ready, .m_valid, .m_running_task, .m_running_priority, .m_is_idle,
        .m_switched, .m_preempted, .m_status, .m_ready_count, .m_sleep_count
    );
endmodule

@@ sv/pss_datapath.sv @@
// Datapath of the priority sleep scheduler: ready/sleep queues, current task,
// slice counter and result register. Depends on pss_pkg.
module pss_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pss_pkg::pss_cmd_t         cmd,
    output pss_pkg::pss_stat_t        stat,
    input  logic [2:0]                s_action,
    input  logic [3:0]                s_task_id,
    input  logic [5:0]                s_priority_req,
    input  logic [31:0]               s_tick_value,
    input  logic [7:0]                cfg_data,
    input  logic                      cfg_we,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic [3:0]                m_running_task,
    output logic [5:0]                m_running_priority,
    output logic                      m_is_idle,
    output logic                      m_switched,
    output logic                      m_preempted,
    output logic [1:0]                m_status,
    output logic [4:0]                m_ready_count,
    output logic [4:0]                m_sleep_count
);
    import pss_pkg::*;

    logic [IdW-1:0]   rid_reg  [MaxTasks];
    logic [PrioW-1:0] rpr_reg  [MaxTasks];
    logic [IdW-1:0]   sid_reg  [MaxTasks];
    logic [WakeW-1:0] swk_reg  [MaxTasks];
    logic [PrioW-1:0] spr_reg  [MaxTasks];
    logic [CntW-1:0]  rlen_reg, slen_reg;
    logic [CntW-1:0]  pos_reg;           // insertion cursor
    logic [IdW-1:0]   cur_id_reg;
    logic [PrioW-1:0] cur_pr_reg;
    logic             idle_reg;
    logic [SliceW-1:0] slice_reg, tslice_reg;
    logic [2:0]       act_reg;
    logic [IdW-1:0]   tid_reg;
    logic [PrioW-1:0] pr_reg;
    logic [WakeW-1:0] tv_reg;
    logic [IdW-1:0]   bid_reg;           // insert buffer
    logic [PrioW-1:0] bpr_reg;
    logic             pidle_reg;
    logic [IdW-1:0]   ptask_reg;
    logic             pre_reg;
    logic [1:0]       st_reg;
    logic             mv_reg;

    logic [IdxW-1:0]  pm1;
    logic [SliceW-1:0] slice_inc;
    assign pm1 = IdxW'(pos_reg - CntW'(1));
    assign slice_inc = (slice_reg == SliceMax) ? slice_reg : slice_reg + SliceW'(1);

    always_comb begin
        stat.action      = act_reg;
        stat.idle        = idle_reg;
        stat.ready_full  = (rlen_reg == CntW'(MaxTasks));
        stat.ready_empty = (rlen_reg == '0);
        stat.sleep_full  = (slen_reg == CntW'(MaxTasks));
        stat.wake_due    = (slen_reg != '0) && (swk_reg[0] <= tv_reg);
        stat.ins_done    = (pos_reg == '0) || !(rpr_reg[pm1] < bpr_reg);
        stat.sins_done   = (pos_reg == '0) || !(swk_reg[pm1] > tv_reg);
        stat.head_ge_cur = !(rpr_reg[0] < cur_pr_reg);
        stat.new_gt_cur  = pr_reg > (idle_reg ? '0 : cur_pr_reg);
        stat.new_gt_req  = rpr_reg[0] > pr_reg;
        stat.slice_expired = slice_inc >= tslice_reg;
        stat.out_busy    = mv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tslice_reg <= SliceReset;
        end else if (cfg_we) begin
            tslice_reg <= cfg_data;
        end
    end

    // queue storage: no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.ins_step) begin
            if (stat.ins_done) begin
                rid_reg[pos_reg[IdxW-1:0]] <= bid_reg;
                rpr_reg[pos_reg[IdxW-1:0]] <= bpr_reg;
            end else begin
                rid_reg[pos_reg[IdxW-1:0]] <= rid_reg[pm1];
                rpr_reg[pos_reg[IdxW-1:0]] <= rpr_reg[pm1];
            end
        end else if (cmd.yield_pop || cmd.dispatch) begin
            for (int i = 0; i < MaxTasks - 1; i++) begin
                rid_reg[i] <= rid_reg[i+1];
                rpr_reg[i] <= rpr_reg[i+1];
            end
        end
        if (cmd.sins_step) begin
            if (stat.sins_done) begin
                sid_reg[pos_reg[IdxW-1:0]] <= cur_id_reg;
                swk_reg[pos_reg[IdxW-1:0]] <= tv_reg;
                spr_reg[pos_reg[IdxW-1:0]] <= cur_pr_reg;
            end else begin
                sid_reg[pos_reg[IdxW-1:0]] <= sid_reg[pm1];
                swk_reg[pos_reg[IdxW-1:0]] <= swk_reg[pm1];
                spr_reg[pos_reg[IdxW-1:0]] <= spr_reg[pm1];
            end
        end else if (cmd.wake_pop) begin
            for (int i = 0; i < MaxTasks - 1; i++) begin
                sid_reg[i] <= sid_reg[i+1];
                swk_reg[i] <= swk_reg[i+1];
                spr_reg[i] <= spr_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg <= s_action;
            tid_reg <= s_task_id;
            pr_reg  <= s_priority_req;
            tv_reg  <= s_tick_value;
            pidle_reg <= idle_reg;
            ptask_reg <= cur_id_reg;
        end
        if (cmd.buf_from_item) begin
            bid_reg <= tid_reg;
            bpr_reg <= pr_reg;
        end else if (cmd.wake_pop) begin
            bid_reg <= sid_reg[0];
            bpr_reg <= spr_reg[0];
        end else if (cmd.yield_pop) begin
            bid_reg <= cur_id_reg;
            bpr_reg <= cur_pr_reg;
        end
        // the requeue after a pop walks the queue as it is after the pop
        if (cmd.yield_pop) pos_reg <= rlen_reg - CntW'(1);
        else if (cmd.ins_start) pos_reg <= rlen_reg;
        else if (cmd.sins_start) pos_reg <= slen_reg;
        else if ((cmd.ins_step && !stat.ins_done) || (cmd.sins_step && !stat.sins_done))
            pos_reg <= pos_reg - CntW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rlen_reg   <= '0;
            slen_reg   <= '0;
            cur_id_reg <= '0;
            cur_pr_reg <= '0;
            idle_reg   <= 1'b1;
            slice_reg  <= '0;
            pre_reg    <= 1'b0;
            st_reg     <= ST_OK;
            mv_reg     <= 1'b0;
        end else begin
            if (cmd.clr_result) begin
                pre_reg <= 1'b0;
                st_reg  <= ST_OK;
            end
            if (cmd.set_preempt) pre_reg <= 1'b1;
            if (cmd.set_full)    st_reg  <= ST_FULL;
            if (cmd.set_invalid) st_reg  <= ST_INVALID;
            if (cmd.ins_step && stat.ins_done) rlen_reg <= rlen_reg + CntW'(1);
            if (cmd.sins_step && stat.sins_done) slen_reg <= slen_reg + CntW'(1);
            if (cmd.wake_pop) slen_reg <= slen_reg - CntW'(1);
            if (cmd.set_prio) cur_pr_reg <= pr_reg;
            if (cmd.yield_pop) begin
                cur_id_reg <= rid_reg[0];
                cur_pr_reg <= rpr_reg[0];
                rlen_reg   <= rlen_reg - CntW'(1);
            end
            if (cmd.dispatch) begin
                if (rlen_reg == '0) begin
                    idle_reg   <= 1'b1;
                    cur_id_reg <= '0;
                    cur_pr_reg <= '0;
                end else begin
                    idle_reg   <= 1'b0;
                    cur_id_reg <= rid_reg[0];
                    cur_pr_reg <= rpr_reg[0];
                    rlen_reg   <= rlen_reg - CntW'(1);
                end
            end
            if (cmd.slice_clr) slice_reg <= '0;
            else if (cmd.slice_inc) slice_reg <= slice_inc;
            if (cmd.out_load) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_running_task     <= idle_reg ? '0 : cur_id_reg;
            m_running_priority <= idle_reg ? '0 : cur_pr_reg;
            m_is_idle          <= idle_reg;
            m_switched         <= (pidle_reg != idle_reg) ||
                                  (!idle_reg && ptask_reg != cur_id_reg);
            m_preempted        <= pre_reg;
            m_status           <= st_reg;
            m_ready_count      <= rlen_reg;
            m_sleep_count      <= slen_reg;
        end
    end
    assign m_valid = mv_reg;

    a_rlen: assert property (@(posedge aclk) disable iff (!aresetn)
        rlen_reg <= CntW'(MaxTasks)) else $error("ready length overflow");
    a_slen: assert property (@(posedge aclk) disable iff (!aresetn)
        slen_reg <= CntW'(MaxTasks)) else $error("sleep length overflow");
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_reg |-> (cur_id_reg == '0 && cur_pr_reg == '0))
        else $error("idle with a task loaded");
endmodule

@@ sv/pss_ctrl.sv @@
// Controller FSM of the priority sleep scheduler; sequences queue walks.
// Depends on pss_pkg.
module pss_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pss_pkg::pss_stat_t stat,
    output pss_pkg::pss_cmd_t  cmd
);
    import pss_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;   // where to go after a ready insert
    logic   ydisp_reg, ydisp_next; // cleared by reset, never set or read; ret_reg picks the yield

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_RESULT;
            ydisp_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ydisp_reg <= ydisp_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !stat.out_busy;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ydisp_next = ydisp_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) state_next = S_DECODE;
            S_DECODE: begin
                unique case (action_t'(stat.action))
                    ACT_TICK: state_next = S_WAKE_CHK;
                    ACT_UNBLOCK, ACT_CREATE: begin
                        if (stat.ready_full) state_next = S_RESULT;
                        else begin
                            state_next = S_RINS;
                            ret_next   = (stat.action == ACT_CREATE && stat.new_gt_cur)
                                         ? S_YIELD : S_RESULT;
                        end
                    end
                    ACT_YIELD: state_next = S_YIELD;
                    ACT_SLEEP: begin
                        if (stat.idle || stat.sleep_full) state_next = S_RESULT;
                        else state_next = S_SINS;
                    end
                    ACT_BLOCK, ACT_EXIT: state_next = stat.idle ? S_RESULT : S_DISPATCH;
                    ACT_SETPRIO: begin
                        if (stat.idle || stat.ready_empty || !stat.new_gt_req)
                            state_next = S_RESULT;
                        else state_next = S_YIELD;
                    end
                    default: state_next = S_RESULT;
                endcase
            end
            S_WAKE_CHK: state_next = stat.wake_due ? S_WAKE_POP : S_SLICE;
            S_WAKE_POP: begin
                state_next = stat.ready_full ? S_WAKE_CHK : S_RINS;
                ret_next   = S_WAKE_CHK;
            end
            S_RINS: if (stat.ins_done) state_next = ret_reg;
            S_SINS: if (stat.sins_done) state_next = S_DISPATCH;
            S_SLICE: state_next = stat.slice_expired ? S_YIELD : S_RESULT;
            S_YIELD: begin
                if (stat.idle) state_next = S_DISPATCH;
                else if (stat.ready_empty || !stat.head_ge_cur) state_next = S_RESULT;
                else state_next = S_YPOP;
            end
            S_YPOP: begin
                state_next = S_RINS;
                ret_next   = S_RESULT;
            end
            S_DISPATCH: state_next = S_RESULT;
            S_RESULT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load_item  = s_valid && s_ready;
                cmd.clr_result = s_valid && s_ready;
            end
            S_DECODE: begin
                unique case (action_t'(stat.action))
                    ACT_UNBLOCK, ACT_CREATE: begin
                        cmd.set_full      = stat.ready_full;
                        cmd.buf_from_item = 1'b1;
                        cmd.ins_start     = !stat.ready_full;
                    end
                    ACT_SLEEP: begin
                        cmd.set_invalid = stat.idle;
                        cmd.set_full    = !stat.idle && stat.sleep_full;
                        cmd.sins_start  = 1'b1;
                    end
                    ACT_BLOCK, ACT_EXIT: cmd.set_invalid = stat.idle;
                    ACT_SETPRIO: begin
                        cmd.set_invalid = stat.idle;
                        cmd.set_prio    = !stat.idle;
                    end
                    default: ;
                endcase
            end
            S_WAKE_CHK: ;
            S_WAKE_POP: begin
                cmd.wake_pop  = 1'b1;
                cmd.set_full  = stat.ready_full;
                cmd.ins_start = 1'b1;
            end
            S_RINS: cmd.ins_step = 1'b1;
            S_SINS: cmd.sins_step = 1'b1;
            S_SLICE: begin
                cmd.slice_inc   = 1'b1;
                cmd.set_preempt = stat.slice_expired;
            end
            S_YIELD: begin
                cmd.slice_clr = 1'b1;
                cmd.ins_start = 1'b1;
            end
            S_YPOP: begin
                cmd.yield_pop = 1'b1;
            end
            S_DISPATCH: begin
                cmd.dispatch  = 1'b1;
                cmd.slice_clr = 1'b1;
            end
            S_RESULT: cmd.out_load = 1'b1;
            default: ;
        endcase
    end

    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_DECODE) else $error("accept lost");
    a_res: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESULT |=> state_reg == S_IDLE) else $error("result stuck");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.ins_step, cmd.sins_step, cmd.yield_pop, cmd.dispatch, cmd.wake_pop}))
        else $error("queue command clash");
endmodule
